// ===== design/mwk_pkg.sv =====
// ----------------------------------------------------------------------------
// mwk_pkg
// shared codes, widths and types of the maze wall knockdown store
// ----------------------------------------------------------------------------
package mwk_pkg;

  localparam int ROW_W    = 5;
  localparam int COL_W    = 5;
  localparam int WALL_W   = 3;
  localparam int STATUS_W = 2;
  localparam int WALLS_W  = 4;
  localparam int LABEL_W  = 10;
  localparam int SIZE_W   = 6;

  localparam logic [WALLS_W-1:0] WALLS_RAISED = 4'hF;
  localparam logic [WALLS_W-1:0] BIT_TOP      = 4'b0001;
  localparam logic [WALLS_W-1:0] BIT_RIGHT    = 4'b0010;
  localparam logic [WALLS_W-1:0] BIT_BOTTOM   = 4'b0100;
  localparam logic [WALLS_W-1:0] BIT_LEFT     = 4'b1000;

  typedef enum logic [WALL_W-1:0] {
    WALL_TOP    = 3'd0,
    WALL_RIGHT  = 3'd1,
    WALL_BOTTOM = 3'd2,
    WALL_LEFT   = 3'd3,
    WALL_NONE   = 3'd4
  } wall_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_KNOCKED      = 2'd0,
    ST_REFUSED      = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    CFG_ROWS    = 1'b0,
    CFG_COLUMNS = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ_HERE,
    S_READ_THERE,
    S_DECIDE,
    S_SWEEP,
    S_RESULT
  } state_t;

  // neighbour decode of one addressed cell
  typedef struct packed {
    logic               in_range;
    logic               has_nb;
    logic [WALLS_W-1:0] own_bit;
    logic [WALLS_W-1:0] far_bit;
  } mwk_nb_t;

endpackage

// ===== design/mwk_ifs.sv =====
// ----------------------------------------------------------------------------
// mwk request and response channels
// valid/ready channels carrying one cell request or one result beat
// ----------------------------------------------------------------------------
interface mwk_req_if import mwk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  column;
  logic [WALL_W-1:0] wall;

  modport source (output valid, output row, output column, output wall, input ready);
  modport sink   (input valid, input row, input column, input wall, output ready);
endinterface

interface mwk_rsp_if import mwk_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WALLS_W-1:0]  walls_now;
  logic [LABEL_W-1:0]  set_label;
  logic                all_joined;

  modport source (output valid, output status, output walls_now, output set_label,
                  output all_joined, input ready);
  modport sink   (input valid, input status, input walls_now, input set_label,
                  input all_joined, output ready);
endinterface

// ===== design/maze_wall_knockdown_set_merge.sv =====
// ----------------------------------------------------------------------------
// maze_wall_knockdown_set_merge
// grid maze store: knocks down walls between cells and merges their sets
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake       payload
//   -------   ---   -------------   ------------------------------------------
//   req       in    valid / ready   row, column, wall
//   rsp       out   valid / ready   status, walls_now, set_label, all_joined
//   cfg       in    cfg_we          cfg_index, cfg_data (rows, columns)
//
// one item at a time; an out of range item goes straight to the result state, a
// refused wall reads both cells first; a knocked wall adds a label sweep over the
// cells in use, one memory read and at most one write per cycle
// reset and every configuration write start a clearing pass over all
// MAX_ROWS*MAX_COLUMNS cells during which req is not ready
// a finished result waits in the output register while the next beat is taken;
// a stalled rsp holds the block in its result state
//
module maze_wall_knockdown_set_merge import mwk_pkg::*; #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLUMNS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  mwk_req_if.sink           req,
  mwk_rsp_if.source         rsp
);

  localparam int CELLS  = MAX_ROWS * MAX_COLUMNS;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int WORD_W = WALLS_W + IDX_W;

  localparam logic [IDX_W-1:0]  LAST_CELL    = IDX_W'(CELLS - 1);
  localparam logic [SIZE_W-1:0] ROWS_RESET   = SIZE_W'((16 > MAX_ROWS) ? MAX_ROWS : 16);
  localparam logic [SIZE_W-1:0] COLS_RESET   = SIZE_W'((16 > MAX_COLUMNS) ? MAX_COLUMNS : 16);
  localparam logic [CNT_W-1:0]  ONE_SET      = CNT_W'(1);

  // cell store: {walls, label} per cell
  logic [WORD_W-1:0] mem [CELLS];
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [WORD_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  logic [WORD_W-1:0] mem_wr_data;

  // configuration
  logic [SIZE_W-1:0]   rows;
  logic [SIZE_W-1:0]   columns;
  logic [SIZE_W-1:0]   size_clamped;
  logic [2*SIZE_W-1:0] used_full;
  logic [CNT_W-1:0]    used;

  // control
  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  clr_idx;
  logic [CNT_W-1:0]  sweep_idx;
  logic              wb_valid;
  logic [IDX_W-1:0]  wb_addr;
  logic [CNT_W-1:0]  set_count;

  // item being worked on
  mwk_nb_t           nb_in;
  logic [IDX_W-1:0]  here_in;
  logic [IDX_W-1:0]  there_in;
  mwk_nb_t           nb;
  logic [IDX_W-1:0]  here;
  logic [IDX_W-1:0]  there;
  logic [WORD_W-1:0] here_word;
  logic [IDX_W-1:0]  big;
  logic [IDX_W-1:0]  small_label;
  logic              merged;

  // output register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [WALLS_W-1:0]  out_walls;
  logic [LABEL_W-1:0]  out_label;
  logic                out_joined;

  // sweep write-back
  logic [IDX_W-1:0]   here_label;
  logic [IDX_W-1:0]   there_label;
  logic [IDX_W-1:0]   wb_label;
  logic [WALLS_W-1:0] wb_walls;
  logic [IDX_W-1:0]   new_label;
  logic [WALLS_W-1:0] new_walls;
  logic               wb_changed;
  logic               out_free;

  mwk_neighbor #(
    .IDX_W (IDX_W)
  ) u_neighbor (
    .row     (req.row),
    .column  (req.column),
    .wall    (req.wall),
    .rows    (rows),
    .columns (columns),
    .nb      (nb_in),
    .here    (here_in),
    .there   (there_in)
  );

  assign used_full = rows * columns;
  assign used      = CNT_W'(used_full);
  assign out_free  = !out_valid || rsp.ready;

  // zero reads as one, above the maximum reads as the maximum
  always_comb begin
    size_clamped = cfg_data;
    if (cfg_data == '0) begin
      size_clamped = SIZE_W'(1);
    end
    if (cfg_index == CFG_ROWS) begin
      if (int'(cfg_data) > MAX_ROWS) begin
        size_clamped = SIZE_W'(MAX_ROWS);
      end
    end else begin
      if (int'(cfg_data) > MAX_COLUMNS) begin
        size_clamped = SIZE_W'(MAX_COLUMNS);
      end
    end
  end

  assign here_label  = here_word[IDX_W-1:0];
  assign there_label = mem_rd_data[IDX_W-1:0];
  assign wb_label    = mem_rd_data[IDX_W-1:0];
  assign wb_walls    = mem_rd_data[WORD_W-1 -: WALLS_W];

  // relabel and drop the facing walls as the sweep passes each cell
  always_comb begin
    new_label = (wb_label == big) ? small_label : wb_label;
    new_walls = wb_walls;
    if (wb_addr == here) begin
      new_walls = new_walls & ~nb.own_bit;
    end
    if (wb_addr == there) begin
      new_walls = new_walls & ~nb.far_bit;
    end
    wb_changed = (new_label != wb_label) || (new_walls != wb_walls);
  end

  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    mem_rd_en   = 1'b0;
    mem_rd_addr = here;
    mem_wr_en   = 1'b0;
    mem_wr_addr = wb_addr;
    mem_wr_data = {new_walls, new_label};
    unique case (state)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_idx;
        mem_wr_data = {WALLS_RAISED, clr_idx};
        if (clr_idx == LAST_CELL) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = nb_in.in_range ? S_READ_HERE : S_RESULT;
        end
      end
      S_READ_HERE: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = here;
        state_next  = S_READ_THERE;
      end
      S_READ_THERE: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = there;
        state_next  = S_DECIDE;
      end
      S_DECIDE: begin
        // read data now holds the neighbour
        if (nb.has_nb && (here_label != there_label)) begin
          state_next = S_SWEEP;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_SWEEP: begin
        // read cell i while writing back cell i-1
        if (sweep_idx != used) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = sweep_idx[IDX_W-1:0];
        end
        if (wb_valid) begin
          mem_wr_en = wb_changed;
        end
        if ((sweep_idx == used) && !wb_valid) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    if (cfg_we) begin
      state_next = S_CLEAR;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      mem_rd_data <= mem[mem_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows      <= ROWS_RESET;
      columns   <= COLS_RESET;
      clr_idx   <= '0;
      set_count <= '0;
      wb_valid  <= 1'b0;
      sweep_idx <= '0;
      merged    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one leaving, else the register empties
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (!cfg_we) begin
            clr_idx <= clr_idx + IDX_W'(1);
          end
          set_count <= used;
        end
        S_IDLE: begin
          merged <= 1'b0;
        end
        S_DECIDE: begin
          sweep_idx <= '0;
          wb_valid  <= 1'b0;
          if (nb.has_nb && (here_label != there_label)) begin
            merged <= 1'b1;
            if (set_count != '0) begin
              set_count <= set_count - CNT_W'(1);
            end
          end
        end
        S_SWEEP: begin
          wb_valid <= (sweep_idx != used);
          if (sweep_idx != used) begin
            sweep_idx <= sweep_idx + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        clr_idx <= '0;
        if (cfg_index == CFG_ROWS) begin
          rows <= size_clamped;
        end else begin
          columns <= size_clamped;
        end
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      nb    <= nb_in;
      here  <= here_in;
      there <= there_in;
    end
    if (state == S_READ_THERE) begin
      here_word <= mem_rd_data;
    end
    if (state == S_DECIDE) begin
      big         <= (here_label > there_label) ? here_label : there_label;
      small_label <= (here_label > there_label) ? there_label : here_label;
    end
    if (state == S_SWEEP) begin
      wb_addr <= sweep_idx[IDX_W-1:0];
    end
    if (state == S_RESULT && out_free) begin
      out_joined <= (set_count == ONE_SET);
      if (!nb.in_range) begin
        out_status <= ST_OUT_OF_RANGE;
        out_walls  <= '0;
        out_label  <= '0;
      end else if (merged) begin
        out_status <= ST_KNOCKED;
        out_walls  <= here_word[WORD_W-1 -: WALLS_W] & ~nb.own_bit;
        out_label  <= LABEL_W'(small_label);
      end else begin
        out_status <= ST_REFUSED;
        out_walls  <= here_word[WORD_W-1 -: WALLS_W];
        out_label  <= LABEL_W'(here_label);
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.walls_now  = out_walls;
  assign rsp.set_label  = out_label;
  assign rsp.all_joined = out_joined;

endmodule

// ===== design/mwk_neighbor.sv =====
// ----------------------------------------------------------------------------
// mwk_neighbor
// cell index, range check and neighbour across the named wall
// ----------------------------------------------------------------------------
module mwk_neighbor import mwk_pkg::*; #(
  parameter int IDX_W = 10
) (
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  column,
  input  logic [WALL_W-1:0] wall,
  input  logic [SIZE_W-1:0] rows,
  input  logic [SIZE_W-1:0] columns,
  output mwk_nb_t           nb,
  output logic [IDX_W-1:0]  here,
  output logic [IDX_W-1:0]  there
);

  localparam int FULL_W = SIZE_W + ROW_W + 1;

  logic [FULL_W-1:0] here_full;
  logic [FULL_W-1:0] there_full;
  logic [SIZE_W-1:0] row_x;
  logic [SIZE_W-1:0] col_x;

  assign row_x     = {1'b0, row};
  assign col_x     = {1'b0, column};
  assign here_full = FULL_W'(row) * FULL_W'(columns) + FULL_W'(column);
  assign here      = IDX_W'(here_full);
  assign there     = IDX_W'(there_full);

  always_comb begin
    nb.in_range = (row_x < rows) && (col_x < columns);
    nb.has_nb   = 1'b0;
    nb.own_bit  = '0;
    nb.far_bit  = '0;
    there_full  = here_full;
    case (wall)
      WALL_TOP: begin
        nb.has_nb  = (row_x != '0);
        there_full = here_full - FULL_W'(columns);
        nb.own_bit = BIT_TOP;
        nb.far_bit = BIT_BOTTOM;
      end
      WALL_RIGHT: begin
        nb.has_nb  = ((col_x + SIZE_W'(1)) < columns);
        there_full = here_full + FULL_W'(1);
        nb.own_bit = BIT_RIGHT;
        nb.far_bit = BIT_LEFT;
      end
      WALL_BOTTOM: begin
        nb.has_nb  = ((row_x + SIZE_W'(1)) < rows);
        there_full = here_full + FULL_W'(columns);
        nb.own_bit = BIT_BOTTOM;
        nb.far_bit = BIT_TOP;
      end
      WALL_LEFT: begin
        nb.has_nb  = (col_x != '0);
        there_full = here_full - FULL_W'(1);
        nb.own_bit = BIT_LEFT;
        nb.far_bit = BIT_RIGHT;
      end
      default: begin
        // query only
        nb.has_nb = 1'b0;
      end
    endcase
  end

endmodule

// ===== tb/sv/maze_wall_knockdown_set_merge_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// maze_wall_knockdown_set_merge_tb
// drives wall knockdown requests into the maze store over a range of grid
// sizes, predicts every result beat with a local model of walls, set labels
// and open set count, and checks each beat field by field as it arrives
// ----------------------------------------------------------------------------
module maze_wall_knockdown_set_merge_tb import mwk_pkg::*; ();

  localparam int MAX_ROWS     = 32;
  localparam int MAX_COLUMNS  = 32;
  localparam int CELLS        = MAX_ROWS * MAX_COLUMNS;
  localparam int SETTLE       = 8;      // idle cycles before a size write
  localparam int LONG_HOLD    = 300;    // long rsp back-pressure stretch
  localparam int RANDOM_ITEMS = 505;
  localparam int TAIL_ITEMS   = 40;

  // one predicted result beat
  typedef struct {
    status_t              status;
    logic [WALLS_W-1:0]   walls;
    logic [LABEL_W-1:0]   label;
    logic                 joined;
  } cell_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [SIZE_W-1:0] cfg_data;

  mwk_req_if req ();
  mwk_rsp_if rsp ();

  maze_wall_knockdown_set_merge #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp)
  );

  // local copy of the maze store
  logic [WALLS_W-1:0] maze_walls [CELLS];
  logic [LABEL_W-1:0] maze_label [CELLS];
  int                 open_sets;
  int                 grid_rows;
  int                 grid_cols;

  cell_result_t expected_results[$];
  int           error_count;
  bit           quiet;              // last part of the run: no idling at all
  bit           rsp_hold_request;   // ask the rsp side for one long stall

  // --------------------------------------------------------------------------
  // clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // the worst case stays well inside this run limit
  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic void model_reinit();
    for (int i = 0; i < CELLS; i++) begin
      maze_walls[i] = WALLS_RAISED;
      maze_label[i] = LABEL_W'(i);
    end
    open_sets = grid_rows * grid_cols;
  endfunction

  // 0 reads as 1, anything past the maximum reads as the maximum
  function automatic int clamp_size(input logic [SIZE_W-1:0] value, input int limit);
    int v;
    v = value;
    if (v < 1) v = 1;
    if (v > limit) v = limit;
    return v;
  endfunction

  function automatic cell_result_t predict_cell(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c,
                                                input logic [WALL_W-1:0] w);
    cell_result_t       res;
    int                 ri, ci, here, there, lo_lab, hi_lab;
    logic               has_nb;
    logic [WALLS_W-1:0] own_bit, far_bit;
    ri = r;
    ci = c;
    res.status = ST_REFUSED;
    res.walls  = '0;
    res.label  = '0;
    res.joined = (open_sets == 1);
    // outside the grid in use: nothing changes, cell fields read as zero
    if (ri >= grid_rows || ci >= grid_cols) begin
      res.status = ST_OUT_OF_RANGE;
      return res;
    end
    here    = ri * grid_cols + ci;
    there   = 0;
    has_nb  = 1'b0;
    own_bit = '0;
    far_bit = '0;
    // border walls have no neighbour; codes past the left wall only query
    case (w)
      WALL_TOP: if (ri > 0) begin
        has_nb = 1'b1; there = here - grid_cols; own_bit = BIT_TOP; far_bit = BIT_BOTTOM;
      end
      WALL_RIGHT: if (ci + 1 < grid_cols) begin
        has_nb = 1'b1; there = here + 1; own_bit = BIT_RIGHT; far_bit = BIT_LEFT;
      end
      WALL_BOTTOM: if (ri + 1 < grid_rows) begin
        has_nb = 1'b1; there = here + grid_cols; own_bit = BIT_BOTTOM; far_bit = BIT_TOP;
      end
      WALL_LEFT: if (ci > 0) begin
        has_nb = 1'b1; there = here - 1; own_bit = BIT_LEFT; far_bit = BIT_RIGHT;
      end
      default: ;
    endcase
    // knock down only when the two cells are still in different sets
    if (has_nb && maze_label[here] != maze_label[there]) begin
      lo_lab = (maze_label[here] < maze_label[there]) ? maze_label[here] : maze_label[there];
      hi_lab = (maze_label[here] < maze_label[there]) ? maze_label[there] : maze_label[here];
      maze_walls[here]  = maze_walls[here] & ~own_bit;
      maze_walls[there] = maze_walls[there] & ~far_bit;
      for (int i = 0; i < grid_rows * grid_cols; i++) begin
        if (maze_label[i] == hi_lab) maze_label[i] = LABEL_W'(lo_lab);
      end
      if (open_sets > 0) open_sets--;
      res.status = ST_KNOCKED;
    end
    res.walls  = maze_walls[here];
    res.label  = maze_label[here];
    res.joined = (open_sets == 1);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // every accepted rsp beat is compared with the oldest prediction
  always @(posedge clk) begin : result_checker
    cell_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat, status", rsp.status, 0);
      end else begin
        want = expected_results.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", rsp.status, want.status);
        if (rsp.walls_now !== want.walls)
          report_mismatch("walls_now", rsp.walls_now, want.walls);
        if (rsp.set_label !== want.label)
          report_mismatch("set_label", rsp.set_label, want.label);
        if (rsp.all_joined !== want.joined)
          report_mismatch("all_joined", rsp.all_joined, want.joined);
      end
    end
  end

  // --------------------------------------------------------------------------
  // rsp side: random stall bursts, one long hold on request, none when quiet
  // --------------------------------------------------------------------------
  initial begin : rsp_ready_driver
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rsp_hold_request) begin
        rsp_hold_request = 1'b0;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // req side and size writes
  // --------------------------------------------------------------------------
  // offer one cell beat; valid stays high on return so back-to-back beats
  // never see a low/high pair in the same step
  task automatic send_cell(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                           input logic [WALL_W-1:0] w);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.row    <= r;
    req.column <= c;
    req.wall   <= w;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_results.push_back(predict_cell(r, c, w));
  endtask

  // sender stops until every outstanding beat has come back
  task automatic drain_results();
    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // size write reinitialises the store and starts a clearing pass
  task automatic write_size(input cfg_index_t idx, input logic [SIZE_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROWS) grid_rows = clamp_size(value, MAX_ROWS);
    else grid_cols = clamp_size(value, MAX_COLUMNS);
    model_reinit();
    @(posedge clk);
    // the clearing pass keeps req low; wait it out, bounded
    for (int k = 0; k < CELLS + 16 && !req.ready; k++) @(posedge clk);
  endtask

  task automatic set_grid(input logic [SIZE_W-1:0] r, input logic [SIZE_W-1:0] c);
    write_size(CFG_ROWS, r);
    write_size(CFG_COLUMNS, c);
  endtask

  // mostly small grids so merges stay short, now and then any 6-bit value
  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 9) == 0) return SIZE_W'($urandom_range(0, 63));
    return SIZE_W'($urandom_range(2, 8));
  endfunction

  // random cell inside the grid in use
  task automatic send_in_grid(input logic [WALL_W-1:0] w);
    send_cell(ROW_W'($urandom_range(0, grid_rows - 1)),
              COL_W'($urandom_range(0, grid_cols - 1)), w);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // default 16x16 grid after reset: queries, out of range, borders, merges
  task automatic test_reset_grid();
    send_cell(0, 0, WALL_NONE);
    send_cell(31, 31, WALL_TOP);         // both fields at their top, off grid
    send_cell(16, 0, WALL_RIGHT);        // first row past the grid
    send_cell(0, 0, WALL_TOP);           // border
    send_cell(15, 15, WALL_RIGHT);       // border
    send_cell(0, 0, WALL_RIGHT);         // knock, labels 0 and 1 join
    send_cell(0, 1, WALL_LEFT);          // already one set
    send_cell(0, 1, WALL_BOTTOM);
    send_cell(1, 1, WALL_LEFT);
    send_cell(1, 0, WALL_TOP);           // closes a loop, refused
    send_cell(2, 2, 3'd7);               // unused wall codes only query
    send_cell(3, 3, 3'd5);
    send_cell(15, 15, WALL_LEFT);
  endtask

  // size registers at and past their limits
  task automatic test_grid_extremes();
    set_grid(6'd0, 6'd0);                // 1x1: joined from the start
    send_cell(0, 0, WALL_TOP);
    send_cell(0, 0, WALL_NONE);
    send_cell(0, 1, WALL_LEFT);
    set_grid(6'd63, 6'd1);               // 32x1
    send_cell(31, 0, WALL_TOP);
    send_cell(31, 0, WALL_BOTTOM);
    set_grid(6'd32, 6'd32);              // full store
    send_cell(31, 31, WALL_LEFT);
    send_cell(31, 31, WALL_RIGHT);
    set_grid(6'd33, 6'd2);               // 32x2
    send_cell(0, 0, WALL_RIGHT);
    set_grid(6'd1, 6'd63);               // 1x32
    send_cell(0, 31, WALL_LEFT);
    send_cell(0, 0, WALL_BOTTOM);
  endtask

  // long rsp stall while beats keep coming, then a full drain
  task automatic test_backpressure();
    set_grid(6'd4, 6'd4);
    rsp_hold_request = 1'b1;
    for (int n = 0; n < 12; n++) send_in_grid(WALL_W'($urandom_range(0, 3)));
    drain_results();
  endtask

  // whole random mazes: mostly in-grid knockdowns, some queries and noise
  task automatic test_random_mazes();
    int unsigned sent, budget, cells, pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_grid(pick_size(), pick_size());
      cells  = grid_rows * grid_cols;
      budget = (cells * 3 + 4 > 60) ? 60 : cells * 3 + 4;
      for (int n = 0; n < budget && sent < RANDOM_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)
          send_in_grid(WALL_W'($urandom_range(0, 3)));
        else if (pick < 90)
          send_in_grid(WALL_W'($urandom_range(4, 7)));
        else
          send_cell(ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 31)),
                    WALL_W'($urandom_range(0, 7)));
        sent++;
      end
    end
  endtask

  // closing stretch with both sides running flat out
  task automatic test_streaming_tail();
    set_grid(6'd6, 6'd6);
    quiet = 1'b1;
    for (int n = 0; n < TAIL_ITEMS; n++) send_in_grid(WALL_W'($urandom_range(0, 4)));
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    error_count      = 0;
    quiet            = 1'b0;
    rsp_hold_request = 1'b0;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_ROWS;
    cfg_data   <= '0;
    req.valid  <= 1'b0;
    req.row    <= '0;
    req.column <= '0;
    req.wall   <= '0;
    grid_rows = 16;
    grid_cols = 16;
    model_reinit();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_grid();
    test_grid_extremes();
    test_backpressure();
    test_random_mazes();
    test_streaming_tail();

    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
